// ===== design/afu_pkg.sv =====
`default_nettype none
// ============================================================================
// afu_pkg
// Shared widths, constants, handshake structs, the sine table and the
// saturation helper of the audio flanger.
// ============================================================================
package afu_pkg;

    // Sample and ring geometry.
    localparam int SAMPLE_W        = 16;
    localparam int DELAY_DEPTH     = 1024;
    localparam int RING_AW         = $clog2(DELAY_DEPTH);
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER         = 1 << SINE_TABLE_BITS;
    localparam int SINE_AW         = SINE_TABLE_BITS + 1;

    // Register field widths.
    localparam int PHASE_W = 32;
    localparam int GAIN_W  = 16;
    localparam int DLY_W   = 10;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Q0.15 unity and the feedback limit of 0.95.
    localparam int UNITY    = 32768;
    localparam int FB_LIMIT = 31129;

    // Shared multiplier operand and product widths.
    localparam int MUL_AW = 27;
    localparam int MUL_BW = 17;
    localparam int PROD_W = MUL_AW + MUL_BW;

    // Q.8 delay sum width and its upper clamp.
    localparam int DQ_W  = (RING_AW + 10 > 21) ? RING_AW + 10 : 21;
    localparam int DMAX  = (DELAY_DEPTH - 2) * 256;
    localparam int SAT_W = 24;

    // Datapath operation codes.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_SD   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_SINE = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_FB   = 4'd4;
    localparam logic [OP_W-1:0] OP_WRITE    = 4'd5;
    localparam logic [OP_W-1:0] OP_RD_A     = 4'd6;
    localparam logic [OP_W-1:0] OP_RD_B     = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_INT  = 4'd8;
    localparam logic [OP_W-1:0] OP_WET      = 4'd9;
    localparam logic [OP_W-1:0] OP_MIX_W    = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT      = 4'd11;

    // Configuration register set.
    typedef struct packed {
        logic        [PHASE_W-1:0] phase_step;
        logic        [GAIN_W-1:0]  depth_gain;
        logic signed [GAIN_W-1:0]  feedback_gain;
        logic        [GAIN_W-1:0]  mix_gain;
        logic        [DLY_W-1:0]   min_delay;
        logic        [DLY_W-1:0]   max_delay;
    } t_cfg;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_load;
        logic            out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_dp_stat;

    typedef logic signed [SAMPLE_W-1:0] t_sine_tab [0:QUARTER];

    // Shift-and-subtract quotient of a non-negative value by a positive one,
    // evaluated only while the sine table is built.
    function automatic longint f_udiv(input longint num, input longint den);
        longint q;
        longint rem;
        q   = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // Quarter-wave sine, amplitude 32767, from a Q30 Taylor series.
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab tab;
        longint    dens [0:5];
        longint    one;
        longint    x;
        longint    x2;
        longint    r;
        longint    s;
        dens[0] = 156;
        dens[1] = 110;
        dens[2] = 72;
        dens[3] = 42;
        dens[4] = 20;
        dens[5] = 6;
        one = 64'sd1 <<< 30;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (64'sd1686629713 * longint'(k)) >>> SINE_TABLE_BITS;
            x2 = (x * x) >>> 30;
            r  = one;
            // The series terms stay positive over the quarter wave.
            for (int i = 0; i < 6; i++) begin
                r = one - (f_udiv(x2 * r, dens[i]) >>> 30);
            end
            s      = (x * r) >>> 30;
            tab[k] = SAMPLE_W'((s * 64'sd32767 + (64'sd1 <<< 29)) >>> 30);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

    localparam logic signed [SAT_W-1:0] S_MAX = SAT_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] S_MIN = -SAT_W'(1 << (SAMPLE_W - 1));

    // Saturate a wide signed value to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        if (v > S_MAX) begin
            c = S_MAX;
        end else if (v < S_MIN) begin
            c = S_MIN;
        end else begin
            c = v;
        end
        return c[SAMPLE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/afu_if.sv =====
`default_nettype none
// ============================================================================
// afu_if
// Valid/ready sample channels of the audio flanger, one for the dry
// input samples and one for the mixed output samples.
// ============================================================================

// Input sample channel.
interface afu_in_if import afu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface afu_out_if import afu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ===== design/afu_ram.sv =====
`default_nettype none
// ============================================================================
// afu_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module afu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/afu_regs.sv =====
`default_nettype none
// ============================================================================
// afu_regs
// APB configuration registers of the flanger, with range clamping of the
// gain registers on write.
// ============================================================================
module afu_regs import afu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [PDATA_W-1:0] i_pwdata,
    output logic      [PDATA_W-1:0] o_prdata,
    output t_cfg                    o_cfg
);

    localparam logic [2:0] REG_PHASE_STEP = 3'd0;
    localparam logic [2:0] REG_DEPTH_GAIN = 3'd1;
    localparam logic [2:0] REG_FEEDBACK   = 3'd2;
    localparam logic [2:0] REG_MIX_GAIN   = 3'd3;
    localparam logic [2:0] REG_MIN_DELAY  = 3'd4;
    localparam logic [2:0] REG_MAX_DELAY  = 3'd5;

    localparam logic        [GAIN_W-1:0] GAIN_MAX = GAIN_W'(UNITY);
    localparam logic signed [GAIN_W-1:0] FB_HI    = GAIN_W'(FB_LIMIT);
    localparam logic signed [GAIN_W-1:0] FB_LO    = -GAIN_W'(FB_LIMIT);

    t_cfg                     r_cfg;
    t_cfg                     n_cfg;
    logic [2:0]               w_index;
    logic                     w_write;
    logic [GAIN_W-1:0]        w_gain;
    logic signed [GAIN_W-1:0] w_fb;

    assign w_index = i_paddr[PADDR_W-1:2];
    assign w_write = i_psel && i_penable && i_pwrite;
    assign w_gain  = i_pwdata[GAIN_W-1:0];
    assign w_fb    = i_pwdata[GAIN_W-1:0];

    // Next register values, with the gains held to their legal ranges.
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_index)
                REG_PHASE_STEP: n_cfg.phase_step = i_pwdata[PHASE_W-1:0];
                REG_DEPTH_GAIN: n_cfg.depth_gain = (w_gain > GAIN_MAX) ? GAIN_MAX : w_gain;
                REG_FEEDBACK: begin
                    if (w_fb > FB_HI) begin
                        n_cfg.feedback_gain = FB_HI;
                    end else if (w_fb < FB_LO) begin
                        n_cfg.feedback_gain = FB_LO;
                    end else begin
                        n_cfg.feedback_gain = w_fb;
                    end
                end
                REG_MIX_GAIN:   n_cfg.mix_gain  = (w_gain > GAIN_MAX) ? GAIN_MAX : w_gain;
                REG_MIN_DELAY:  n_cfg.min_delay = i_pwdata[DLY_W-1:0];
                REG_MAX_DELAY:  n_cfg.max_delay = i_pwdata[DLY_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with reset defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= PHASE_W'(44739);
            r_cfg.depth_gain    <= GAIN_W'(16384);
            r_cfg.feedback_gain <= '0;
            r_cfg.mix_gain      <= GAIN_W'(16384);
            r_cfg.min_delay     <= DLY_W'(48);
            r_cfg.max_delay     <= DLY_W'(480);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back decoder.
    always_comb begin
        unique case (w_index)
            REG_PHASE_STEP: o_prdata = r_cfg.phase_step;
            REG_DEPTH_GAIN: o_prdata = PDATA_W'(r_cfg.depth_gain);
            REG_FEEDBACK:   o_prdata = PDATA_W'(r_cfg.feedback_gain);
            REG_MIX_GAIN:   o_prdata = PDATA_W'(r_cfg.mix_gain);
            REG_MIN_DELAY:  o_prdata = PDATA_W'(r_cfg.min_delay);
            REG_MAX_DELAY:  o_prdata = PDATA_W'(r_cfg.max_delay);
            default:        o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== design/afu_ctrl.sv =====
`default_nettype none
// ============================================================================
// afu_ctrl
// Sequencer of the flanger: runs the ring clearing pass after reset, then
// steps the datapath through the operations of one sample and owns the
// handshakes of both sample channels.
// ============================================================================
module afu_ctrl import afu_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_MUL_SD   = 4'd2;
    localparam logic [3:0] ST_MUL_SINE = 4'd3;
    localparam logic [3:0] ST_MUL_FB   = 4'd4;
    localparam logic [3:0] ST_WRITE    = 4'd5;
    localparam logic [3:0] ST_RD_A     = 4'd6;
    localparam logic [3:0] ST_RD_B     = 4'd7;
    localparam logic [3:0] ST_MUL_INT  = 4'd8;
    localparam logic [3:0] ST_WET      = 4'd9;
    localparam logic [3:0] ST_MIX_W    = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_in_load;
    logic       w_out_load;

    assign w_in_load  = (r_state == ST_IDLE) && i_in_valid;
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // Next state: clearing pass, wait for a sample, walk its operations, wait on output.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_MUL_SD;
            ST_MUL_SD:   n_state = ST_MUL_SINE;
            ST_MUL_SINE: n_state = ST_MUL_FB;
            ST_MUL_FB:   n_state = ST_WRITE;
            ST_WRITE:    n_state = ST_RD_A;
            ST_RD_A:     n_state = ST_RD_B;
            ST_RD_B:     n_state = ST_MUL_INT;
            ST_MUL_INT:  n_state = ST_WET;
            ST_WET:      n_state = ST_MIX_W;
            ST_MIX_W:    n_state = ST_OUT;
            ST_OUT:      if (w_out_load) n_state = ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    // Datapath operation for each state.
    always_comb begin
        o_cmd.in_load  = w_in_load;
        o_cmd.out_load = w_out_load;
        unique case (r_state)
            ST_CLEAR:    o_cmd.op = OP_CLEAR;
            ST_MUL_SD:   o_cmd.op = OP_MUL_SD;
            ST_MUL_SINE: o_cmd.op = OP_MUL_SINE;
            ST_MUL_FB:   o_cmd.op = OP_MUL_FB;
            ST_WRITE:    o_cmd.op = OP_WRITE;
            ST_RD_A:     o_cmd.op = OP_RD_A;
            ST_RD_B:     o_cmd.op = OP_RD_B;
            ST_MUL_INT:  o_cmd.op = OP_MUL_INT;
            ST_WET:      o_cmd.op = OP_WET;
            ST_MIX_W:    o_cmd.op = OP_MIX_W;
            ST_OUT:      o_cmd.op = OP_OUT;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    // The output register stays full until the sink takes the request.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/afu_dp.sv =====
`default_nettype none
// ============================================================================
// afu_dp
// Datapath of the flanger: LFO and sine lookup, one shared multiplier, the
// delay ring RAM, interpolation, the dry/wet mix and the output register.
// ============================================================================
module afu_dp import afu_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    input  wire t_cfg                       i_cfg,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic signed      [SAMPLE_W-1:0] o_sample_out,
    output t_dp_stat                        o_stat
);

    localparam logic signed [DQ_W-1:0]    DQ_MAX   = DQ_W'(DMAX);
    localparam logic        [RING_AW-1:0] RING_END = RING_AW'(DELAY_DEPTH - 1);

    // Control state.
    logic        [PHASE_W-1:0]  r_phase;
    logic        [RING_AW-1:0]  r_widx;
    logic        [RING_AW-1:0]  r_clr_addr;
    logic signed [SAMPLE_W-1:0] r_last_wet;

    // Per-sample working registers.
    logic signed [SAMPLE_W-1:0] r_dry;
    logic signed [SAMPLE_W-1:0] r_sine;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;
    logic        [RING_AW-1:0]  r_di;
    logic        [7:0]          r_fr;
    logic        [RING_AW-1:0]  r_pa;
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [SAMPLE_W-1:0] r_out;

    logic        [1:0]                 w_quad;
    logic        [SINE_TABLE_BITS-1:0] w_idx;
    logic        [SINE_AW-1:0]         w_saddr;
    logic signed [SAMPLE_W-1:0]        w_sval;
    logic signed [DLY_W:0]             w_span;
    logic signed [MUL_AW-1:0]          w_mul_a;
    logic signed [MUL_BW-1:0]          w_mul_b;
    logic signed [PROD_W-1:0]          w_prod;
    logic signed [PROD_W-1:0]          w_sw_sum;
    logic signed [DQ_W-1:0]            w_dq;
    logic        [RING_AW+7:0]         w_dqc;
    logic signed [PROD_W-1:0]          w_fb_sum;
    logic signed [SAMPLE_W+1:0]        w_fb;
    logic signed [SAMPLE_W+1:0]        w_wr;
    logic signed [RING_AW:0]           w_pa_diff;
    logic        [RING_AW:0]           w_pa;
    logic        [RING_AW-1:0]         w_pb;
    logic        [SAMPLE_W-1:0]        w_rdata;
    logic signed [SAMPLE_W:0]          w_diff;
    logic signed [PROD_W-1:0]          w_wet_sum;
    logic signed [PROD_W-1:0]          w_mix_sum;
    logic                              w_we;
    logic        [RING_AW-1:0]         w_waddr;
    logic        [SAMPLE_W-1:0]        w_wdata;
    logic        [RING_AW-1:0]         w_raddr;

    // Quarter-wave sine lookup: mirror odd quadrants, negate the lower half.
    assign w_quad  = r_phase[PHASE_W-1 -: 2];
    assign w_idx   = r_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    assign w_saddr = w_quad[0] ? (SINE_AW'(QUARTER) - {1'b0, w_idx}) : {1'b0, w_idx};
    assign w_sval  = SINE_TAB[w_saddr];

    assign w_span = $signed({1'b0, i_cfg.max_delay}) - $signed({1'b0, i_cfg.min_delay});

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_MUL_SD: begin
                w_mul_a = MUL_AW'(w_span);
                w_mul_b = {1'b0, i_cfg.depth_gain};
            end
            OP_MUL_SINE: begin
                w_mul_a = r_prod[MUL_AW-1:0];
                w_mul_b = MUL_BW'(r_sine);
            end
            OP_MUL_FB: begin
                w_mul_a = MUL_AW'(i_cfg.feedback_gain);
                w_mul_b = MUL_BW'(r_last_wet);
            end
            OP_MUL_INT: begin
                w_mul_a = MUL_AW'(w_diff);
                w_mul_b = {{(MUL_BW - 8){1'b0}}, r_fr};
            end
            OP_WET: begin
                w_mul_a = MUL_AW'(r_dry);
                w_mul_b = MUL_BW'(UNITY) - {1'b0, i_cfg.mix_gain};
            end
            OP_MIX_W: begin
                w_mul_a = MUL_AW'(r_last_wet);
                w_mul_b = {1'b0, i_cfg.mix_gain};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // Delay in Q.8: min + span/2 + rounded swing term, clamped into the ring.
    assign w_sw_sum = r_prod + PROD_W'(64'sd4194304);
    assign w_dq = DQ_W'($signed({1'b0, i_cfg.min_delay, 8'h00}))
                + (DQ_W'(w_span) <<< 7)
                + DQ_W'($signed(w_sw_sum[PROD_W-1:23]));

    always_comb begin
        if (w_dq < 0) begin
            w_dqc = '0;
        end else if (w_dq > DQ_MAX) begin
            w_dqc = DQ_MAX[RING_AW+7:0];
        end else begin
            w_dqc = w_dq[RING_AW+7:0];
        end
    end

    // Ring write value: dry plus rounded feedback, saturated.
    assign w_fb_sum = r_prod + PROD_W'(16384);
    assign w_fb     = w_fb_sum[15+SAMPLE_W+1:15];
    assign w_wr     = (SAMPLE_W + 2)'(r_dry) + w_fb;

    // Read positions of the two interpolation taps.
    assign w_pa_diff = $signed({1'b0, r_widx}) - $signed({1'b0, r_di});
    assign w_pa      = w_pa_diff[RING_AW] ? (w_pa_diff + (RING_AW + 1)'(DELAY_DEPTH))
                                          : w_pa_diff;
    assign w_pb      = (r_pa == '0) ? RING_END : (r_pa - 1'b1);

    // Interpolation and mix sums.
    assign w_diff    = $signed({w_rdata[SAMPLE_W-1], w_rdata}) - $signed({r_a[SAMPLE_W-1], r_a});
    assign w_wet_sum = (PROD_W'(r_a) <<< 8) + r_prod + PROD_W'(128);
    assign w_mix_sum = r_acc + r_prod + PROD_W'(16384);

    // Delay ring port control.
    assign w_we    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_WRITE);
    assign w_waddr = (i_cmd.op == OP_CLEAR) ? r_clr_addr : r_widx;
    assign w_wdata = (i_cmd.op == OP_CLEAR) ? '0 : f_sat(SAT_W'(w_wr));
    assign w_raddr = (i_cmd.op == OP_RD_B) ? w_pb : r_pa;

    afu_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // State that persists across samples.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_widx     <= '0;
            r_clr_addr <= '0;
            r_last_wet <= '0;
        end else begin
            if (i_cmd.in_load) begin
                r_phase <= r_phase + i_cfg.phase_step;
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= (r_clr_addr == RING_END) ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.op == OP_WET) begin
                r_last_wet <= w_wet_sum[8+SAMPLE_W-1:8];
                r_widx     <= (r_widx == RING_END) ? '0 : r_widx + 1'b1;
            end
        end
    end

    // Working registers of the sample in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_dry  <= i_sample_in;
            r_sine <= w_quad[1] ? -w_sval : w_sval;
        end
        case (i_cmd.op)
            OP_MUL_SD, OP_MUL_SINE, OP_MUL_INT, OP_WET: begin
                r_prod <= w_prod;
            end
            OP_MUL_FB: begin
                r_prod <= w_prod;
                r_di   <= w_dqc[RING_AW+7:8];
                r_fr   <= w_dqc[7:0];
            end
            OP_WRITE: begin
                r_pa <= w_pa[RING_AW-1:0];
            end
            OP_RD_B: begin
                r_a <= w_rdata;
            end
            OP_MIX_W: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out <= f_sat(w_mix_sum[15+SAT_W-1:15]);
        end
    end

    assign o_sample_out    = r_out;
    assign o_stat.clr_last = (r_clr_addr == RING_END);

endmodule
`default_nettype wire

// ===== design/audio_flanger_unit.sv =====
`default_nettype none
// ============================================================================
// audio_flanger_unit
// Flanger with feedback: one signed 16-bit sample in, one flanged sample out.
// ============================================================================
// After reset the block clears the delay ring and holds its input ready low
// during that pass; configuration writes are taken at any time. Each sample
// then steps through its delay, feedback, ring write, two ring reads,
// interpolation, wet and mix operations to a loaded output register, on the
// single shared 27x17 multiplier and the one ring read port, which the
// sequencer visits one operation per cycle unless it waits on the output. A
// new sample is accepted once the previous one is in the output register;
// a stalled output holds the finished sample and delays only the next one.
// Registers are written over APB at byte address 4 times the register
// index; depth and mix gains above 32768 and feedback beyond +-0.95 are
// clamped on write. Write configuration only while no sample is in flight.
module audio_flanger_unit import afu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    afu_in_if.sink                  i_in,
    afu_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    // Configuration registers.
    afu_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // Sequencer.
    afu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    afu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (w_cfg),
        .i_sample_in  (i_in.sample_in),
        .o_sample_out (o_out.sample_out),
        .o_stat       (w_stat)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign pready      = 1'b1;

endmodule
`default_nettype wire

// ===== design/afu_checker.sv =====
`default_nettype none
// ============================================================================
// afu_checker
// Port-level checks of the flanger's sample channels, bound to the top level.
// ============================================================================
module afu_checker import afu_pkg::*; (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [SAMPLE_W-1:0] i_out_sample
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // One sample is worked on at a time, so acceptance never repeats at once.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // A result cannot appear in the cycle right after a sample is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(w_in_acc))
        else $error("output valid rose directly after an input request");

    // A stalled output request stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled output request keeps its sample.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample))
        else $error("output sample changed while stalled");

endmodule

bind audio_flanger_unit afu_checker u_afu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out)
);
`default_nettype wire

// ===== sim/tb_audio_flanger_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_audio_flanger_unit
// Self-checking bench for the flanger. A scoreboard class carries its own
// model of the LFO, the delay ring, the feedback path and the mix. It predicts
// each output sample from the dry samples that the block takes, and it checks
// the outputs in order. The dry side sends in bursts, the output side stalls
// on a changing pattern, and APB writes step the settings between phases.
// ============================================================================
module tb_audio_flanger_unit;
    import afu_pkg::*;

    // Register indexes on the APB port; the last two lie outside the list.
    typedef enum int {
        REG_PHASE_STEP    = 0,
        REG_DEPTH_GAIN    = 1,
        REG_FEEDBACK_GAIN = 2,
        REG_MIX_GAIN      = 3,
        REG_MIN_DELAY     = 4,
        REG_MAX_DELAY     = 5,
        REG_SPARE_A       = 6,
        REG_SPARE_B       = 7
    } reg_index_e;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t sample_q[$];

    localparam int RANDOM_ITEMS   = 750;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 24;

    // Predicts the flanged sample for every dry sample and checks the outputs.
    class flanger_checker;
        sample_t            sine_quarter [0:QUARTER];
        sample_t            ring [0:DELAY_DEPTH-1];
        logic [RING_AW-1:0] wr_ptr;
        logic [PHASE_W-1:0] lfo_phase;
        sample_t            prev_wet;
        logic [PHASE_W-1:0] phase_step;
        logic [GAIN_W-1:0]  depth_gain;
        sample_t            feedback_gain;
        logic [GAIN_W-1:0]  mix_gain;
        logic [DLY_W-1:0]   min_delay;
        logic [DLY_W-1:0]   max_delay;
        sample_t            expected_out [$];
        int                 errors;

        function new();
            longint divs [0:5];
            longint x;
            longint x2;
            longint r;
            longint s;
            divs = '{156, 110, 72, 42, 20, 6};
            // Quarter sine of amplitude 32767 from a Taylor series in Q30.
            for (int k = 0; k <= QUARTER; k++) begin
                x  = longint'((64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS);
                x2 = (x * x) >>> 30;
                r  = 64'sd1 <<< 30;
                for (int i = 0; i < 6; i++) begin
                    r = (64'sd1 <<< 30) - (((x2 * r) / divs[i]) >>> 30);
                end
                s = (x * r) >>> 30;
                sine_quarter[k] = SAMPLE_W'((s * 32767 + (64'sd1 <<< 29)) >>> 30);
            end
            foreach (ring[i]) ring[i] = '0;
            wr_ptr        = '0;
            lfo_phase     = '0;
            prev_wet      = '0;
            phase_step    = 32'd44739;
            depth_gain    = 16'd16384;
            feedback_gain = '0;
            mix_gain      = 16'd16384;
            min_delay     = 10'd48;
            max_delay     = 10'd480;
            errors        = 0;
        endfunction

        function sample_t clip(input longint v);
            if (v > 32767) begin
                return 16'sh7FFF;
            end else if (v < -32768) begin
                return 16'sh8000;
            end
            return SAMPLE_W'(v);
        endfunction

        // Registers keep their low bits; gains and feedback are clamped on write.
        function void write_reg(input reg_index_e idx, input logic [PDATA_W-1:0] v);
            int fb;
            case (idx)
                REG_PHASE_STEP: begin
                    phase_step = v;
                end
                REG_DEPTH_GAIN: begin
                    depth_gain = (v[15:0] > UNITY) ? GAIN_W'(UNITY) : v[15:0];
                end
                REG_FEEDBACK_GAIN: begin
                    fb = int'($signed(v[15:0]));
                    if (fb > FB_LIMIT) fb = FB_LIMIT;
                    if (fb < -FB_LIMIT) fb = -FB_LIMIT;
                    feedback_gain = GAIN_W'(fb);
                end
                REG_MIX_GAIN: begin
                    mix_gain = (v[15:0] > UNITY) ? GAIN_W'(UNITY) : v[15:0];
                end
                REG_MIN_DELAY: begin
                    min_delay = v[DLY_W-1:0];
                end
                REG_MAX_DELAY: begin
                    max_delay = v[DLY_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // One dry sample in: sweep the delay, write the ring, read and mix.
        function void take_dry(input sample_t dry);
            longint                     dry_l;
            longint                     sine;
            longint                     span;
            longint                     dq8;
            longint                     frac;
            longint                     a;
            longint                     b;
            longint                     wet;
            longint                     mixed;
            logic [1:0]                 quad;
            logic [SINE_TABLE_BITS-1:0] tidx;
            logic [RING_AW-1:0]         pa;
            logic [RING_AW-1:0]         pb;
            dry_l = dry;

            // LFO: quadrant from the top bits, mirrored and negated as needed.
            quad = lfo_phase[31:30];
            tidx = lfo_phase[29 -: SINE_TABLE_BITS];
            sine = quad[0] ? sine_quarter[QUARTER - tidx] : sine_quarter[tidx];
            if (quad[1]) sine = -sine;

            // Delay in samples with 8 fraction bits, clamped to the ring.
            span = longint'(max_delay) - longint'(min_delay);
            dq8  = longint'(min_delay) * 256 + span * 128
                 + ((span * 128 * longint'(depth_gain) * sine + (64'sd1 <<< 29)) >>> 30);
            if (dq8 < 0) dq8 = 0;
            if (dq8 > longint'(DMAX)) dq8 = longint'(DMAX);
            lfo_phase = lfo_phase + phase_step;

            // Ring write with feedback from the last wet sample.
            ring[wr_ptr] = clip(dry_l
                + ((longint'(feedback_gain) * longint'(prev_wet) + 16384) >>> 15));

            // Linear interpolation; delay zero is the sample just written.
            frac = dq8 & 255;
            pa   = wr_ptr - RING_AW'(dq8 >>> 8);
            pb   = pa - 1'b1;
            a    = ring[pa];
            b    = ring[pb];
            wet  = (a * 256 + (b - a) * frac + 128) >>> 8;
            prev_wet = SAMPLE_W'(wet);
            wr_ptr   = wr_ptr + 1'b1;

            mixed = ((longint'(UNITY) - longint'(mix_gain)) * dry_l
                  + longint'(mix_gain) * wet + 16384) >>> 15;
            expected_out.push_back(clip(mixed));
        endfunction

        function void check_result(input sample_t got);
            sample_t want;
            if (expected_out.size() == 0) begin
                $display("%0t: sample_out %0d arrived with nothing expected", $time, got);
                errors++;
            end else begin
                want = expected_out.pop_front();
                if (got !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 idle_cycles = 0;

    afu_in_if  in_ch ();
    afu_out_if out_ch ();

    flanger_checker chk = new();

    audio_flanger_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Output side: check each accepted request, stall on a pattern that changes.
    initial begin
        logic [7:0] stall_mask;
        logic [2:0] stall_bit;
        int         stall_age;
        stall_mask = '1;
        stall_bit  = '0;
        stall_age  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                chk.check_result(out_ch.sample_out);
            end
            if (stall_age == 0) begin
                stall_age = $urandom_range(16, 64);
                if ($urandom_range(0, 2) == 0) begin
                    stall_mask = '1;
                end else begin
                    stall_mask = 8'($urandom) | (8'd1 << $urandom_range(0, 7));
                end
            end
            stall_age--;
            out_ch.ready <= stall_mask[stall_bit];
            stall_bit = stall_bit + 1'b1;
        end
    end

    // Watchdog on cycles with no accepted request and no register access.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(input reg_index_e idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        chk.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send a list of dry samples in bursts with random gaps between them.
    task automatic play_dry(input sample_q list);
        int burst;
        burst = $urandom_range(1, 24);
        foreach (list[i]) begin
            in_ch.valid     <= 1'b1;
            in_ch.sample_in <= list[i];
            do @(posedge i_clk); while (!in_ch.ready);
            chk.take_dry(list[i]);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    in_ch.valid     <= 1'b0;
                    in_ch.sample_in <= 16'($urandom);
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every predicted sample has come out.
    task automatic drain();
        while (chk.expected_out.size() != 0) @(posedge i_clk);
    endtask

    function automatic sample_t random_dry();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1, 2: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Some writes carry junk above the field width.
    function automatic logic [PDATA_W-1:0] with_junk(input logic [PDATA_W-1:0] v,
                                                      input int w);
        return v | (($urandom_range(0, 3) == 0) ? ($urandom << w) : 32'd0);
    endfunction

    function automatic logic [PDATA_W-1:0] random_gain();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'(UNITY);
            2: return $urandom_range(UNITY + 1, 65535);
            default: return $urandom_range(0, UNITY);
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] random_delay();
        case ($urandom_range(0, 7))
            0: return 32'd1;
            1: return 32'd1022;
            2: return ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd1023;
            default: return $urandom_range(1, 1022);
        endcase
    endfunction

    // New settings for a random phase; each register is rewritten most times.
    task automatic shuffle_settings();
        logic [PDATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'd0;
            1: v = '1;
            2, 3: v = $urandom_range(0, 1 << 22);
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 3) != 0) reg_write(REG_PHASE_STEP, v);
        if ($urandom_range(0, 3) != 0) reg_write(REG_DEPTH_GAIN, with_junk(random_gain(), 16));
        case ($urandom_range(0, 5))
            0: v = 32'(FB_LIMIT);
            1: v = 32'(-FB_LIMIT);
            2: v = $urandom_range(0, 65535);
            default: v = 32'(int'($urandom_range(0, 2 * FB_LIMIT)) - FB_LIMIT);
        endcase
        if ($urandom_range(0, 3) != 0) reg_write(REG_FEEDBACK_GAIN, with_junk(v, 16));
        if ($urandom_range(0, 3) != 0) reg_write(REG_MIX_GAIN, with_junk(random_gain(), 16));
        if ($urandom_range(0, 3) != 0) reg_write(REG_MIN_DELAY, with_junk(random_delay(), 10));
        if ($urandom_range(0, 3) != 0) reg_write(REG_MAX_DELAY, with_junk(random_delay(), 10));
        if ($urandom_range(0, 7) == 0) begin
            reg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        end
    endtask

    // Main sequence: reset, directed phases, random phases, final check.
    initial begin
        sample_q list;
        int      left;
        int      n;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings with full-scale and near-zero samples.
        list = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh8000};
        play_dry(list);
        drain();

        // Gains above range, feedback above range, min above max, largest phase step.
        reg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
        reg_write(REG_DEPTH_GAIN, 32'h0000_FFFF);
        reg_write(REG_FEEDBACK_GAIN, 32'h0000_7FFF);
        reg_write(REG_MIX_GAIN, 32'h0000_FFFF);
        reg_write(REG_MIN_DELAY, 32'h0000_03FF);
        reg_write(REG_MAX_DELAY, 32'h0000_0000);
        reg_write(REG_SPARE_A, 32'hDEAD_0001);
        list = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000};
        play_dry(list);
        drain();

        // Feedback below range, zero depth and mix, widest delay span.
        reg_write(REG_PHASE_STEP, 32'h4000_0000);
        reg_write(REG_DEPTH_GAIN, 32'h0000_0000);
        reg_write(REG_FEEDBACK_GAIN, 32'h0000_8000);
        reg_write(REG_MIX_GAIN, 32'h0000_0000);
        reg_write(REG_MIN_DELAY, 32'h0000_0000);
        reg_write(REG_MAX_DELAY, 32'h0000_03FF);
        list = '{16'sh3039, 16'sh8000, 16'sh7FFF, 16'shFFFF};
        play_dry(list);
        drain();

        // Full depth and mix, feedback at its limit, delay range at the ends.
        reg_write(REG_PHASE_STEP, 32'h1000_0000);
        reg_write(REG_DEPTH_GAIN, 32'(UNITY));
        reg_write(REG_FEEDBACK_GAIN, 32'(FB_LIMIT));
        reg_write(REG_MIX_GAIN, 32'(UNITY));
        reg_write(REG_MIN_DELAY, 32'd1);
        reg_write(REG_MAX_DELAY, 32'd1022);
        reg_write(REG_SPARE_B, 32'h0000_BEEF);
        list = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
        play_dry(list);
        drain();

        // Random phases, each under fresh settings.
        left = RANDOM_ITEMS;
        while (left > 0) begin
            n = $urandom_range(60, 140);
            if (n > left) n = left;
            shuffle_settings();
            list.delete();
            for (int i = 0; i < n; i++) list.push_back(random_dry());
            play_dry(list);
            drain();
            left -= n;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk.errors == 0 && chk.expected_out.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
